[sv/lkx_pkg.sv]
// Shared types, constants and the key character set for the LCG keyed XOR stream cipher.
`timescale 1ns / 1ps
`default_nettype none
package lkx_pkg;

   localparam int KEY_LEN = 32;
   localparam int KEY_IDX_W = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

   localparam logic [31:0] LCG_MUL = 32'd214013;
   localparam logic [31:0] LCG_INC = 32'd2531011;

   localparam logic [14:0] CHARSET_SIZE = 15'd61;
   localparam logic [10:0] RECIP_61 = 11'd1074;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_RESEED = 2'd0;
   localparam logic [1:0] ACT_KEYGEN = 2'd1;
   localparam logic [1:0] ACT_ENCRYPT = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_RESEED = 2'd0;
   localparam cmd_type CMD_KEYGEN = 2'd1;
   localparam cmd_type CMD_ENCRYPT = 2'd2;

   typedef struct packed {
      cmd_type cmd;
      logic [7:0] data;
   } q_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [7:0] charset(input logic [5:0] idx);
      logic [7:0] code;
      code = {2'b00, idx};
      if (idx < 6'd26) begin
         charset = 8'h61 + code;
      end else if (idx < 6'd52) begin
         charset = 8'h41 + code - 8'd26;
      end else begin
         charset = 8'h31 + code - 8'd52;
      end
   endfunction

endpackage
`default_nettype wire

[sv/lkx_front.sv]
// Front end: accepts requests, decodes the action and pushes commands into the queue.
`timescale 1ns / 1ps
`default_nettype none
module lkx_front (
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [15:0]          req_tdata,  // [1:0] action, [9:2] data_in
   input  wire lkx_pkg::q_status_type q_stat,
   output logic                      q_push,
   output lkx_pkg::q_entry_type      q_wdata
);
   import lkx_pkg::*;

   logic [1:0] action;
   logic       cmd_ok;

   assign action = req_tdata[1:0];
   assign req_tready = !q_stat.full;

   always_comb begin
      cmd_ok = 1'b1;
      q_wdata.data = req_tdata[9:2];
      unique case (action)
         ACT_RESEED: q_wdata.cmd = CMD_RESEED;
         ACT_KEYGEN: q_wdata.cmd = CMD_KEYGEN;
         ACT_ENCRYPT: q_wdata.cmd = CMD_ENCRYPT;
         default: begin
            q_wdata.cmd = CMD_RESEED;
            cmd_ok = 1'b0;
         end
      endcase
   end

   // Unused action codes are accepted and dropped here.
   assign q_push = req_tvalid && req_tready && cmd_ok;

endmodule
`default_nettype wire

[sv/lkx_queue.sv]
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps
`default_nettype none
module lkx_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_push,
   input  wire lkx_pkg::q_entry_type q_wdata,
   input  wire logic                 q_pop,
   output lkx_pkg::q_entry_type      q_rdata,
   output lkx_pkg::q_status_type     q_stat
);
   import lkx_pkg::*;

   q_entry_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule
`default_nettype wire

[sv/lkx_back.sv]
// Back end: generator, key store, key sequencer, XOR path and the response register.
`timescale 1ns / 1ps
`default_nettype none
module lkx_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic [31:0]           csr_wdata,
   input  wire lkx_pkg::q_entry_type  q_rdata,
   input  wire lkx_pkg::q_status_type q_stat,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,  // [7:0] data_out
   output logic                       rsp_tuser,  // [0] is_key
   output logic                       rsp_tlast
);
   import lkx_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_STEP = 2'd1;
   localparam logic [1:0] PH_DIV = 2'd2;
   localparam logic [1:0] PH_EMIT = 2'd3;

   logic [31:0] seed_ff;
   logic [31:0] gen_ff, gen_in;
   logic [1:0]  phase_ff, phase_in;
   logic [KEY_IDX_W-1:0] cnt_ff, cnt_in;
   logic [KEY_IDX_W-1:0] pos_ff, pos_in;
   logic [7:0]  key_ff [KEY_LEN];
   logic [14:0] r_ff, r_in;
   logic [25:0] prod_ff, prod_in;
   logic        out_vld_ff, out_vld_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic        out_key_ff, out_key_in;
   logic        out_last_ff, out_last_in;

   logic        out_free;
   logic        key_wen;
   logic [7:0]  key_char;
   logic [9:0]  quot;
   logic [14:0] rem_raw;
   logic [14:0] rem_fix;

   assign out_free = !out_vld_ff || rsp_tready;

   // The quotient estimate is low by at most one, so one correction step suffices.
   assign quot = prod_ff[25:16];
   assign rem_raw = r_ff - 15'(quot * CHARSET_SIZE);
   assign rem_fix = (rem_raw >= CHARSET_SIZE) ? rem_raw - CHARSET_SIZE : rem_raw;
   assign key_char = charset(rem_fix[5:0]);

   always_comb begin
      gen_in = gen_ff;
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      r_in = r_ff;
      prod_in = prod_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_key_in = out_key_ff;
      out_last_in = out_last_ff;
      q_pop = 1'b0;
      key_wen = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (!q_stat.empty) begin
               unique case (q_rdata.cmd)
                  CMD_RESEED: begin
                     q_pop = 1'b1;
                     gen_in = seed_ff;
                  end
                  CMD_KEYGEN: begin
                     q_pop = 1'b1;
                     cnt_in = '0;
                     phase_in = PH_STEP;
                  end
                  CMD_ENCRYPT: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        out_vld_in = 1'b1;
                        out_data_in = q_rdata.data ^ key_ff[pos_ff];
                        out_key_in = 1'b0;
                        out_last_in = 1'b1;
                        pos_in = (pos_ff == KEY_IDX_W'(KEY_LEN - 1)) ? '0 : pos_ff + 1'b1;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         PH_STEP: begin
            gen_in = gen_ff * LCG_MUL + LCG_INC;
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            r_in = gen_ff[30:16];
            prod_in = 26'(gen_ff[30:16] * RECIP_61);
            phase_in = PH_EMIT;
         end
         PH_EMIT: begin
            if (out_free) begin
               key_wen = 1'b1;
               out_vld_in = 1'b1;
               out_data_in = key_char;
               out_key_in = 1'b1;
               out_last_in = (cnt_ff == KEY_IDX_W'(KEY_LEN - 1));
               if (cnt_ff == KEY_IDX_W'(KEY_LEN - 1)) begin
                  pos_in = '0;
                  phase_in = PH_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  phase_in = PH_STEP;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         gen_ff <= '0;
         phase_ff <= PH_IDLE;
         cnt_ff <= '0;
         pos_ff <= '0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < KEY_LEN; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         if (csr_wen) begin
            seed_ff <= csr_wdata;
         end
         gen_ff <= gen_in;
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         out_vld_ff <= out_vld_in;
         if (key_wen) begin
            key_ff[cnt_ff] <= key_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      prod_ff <= prod_in;
      out_data_ff <= out_data_in;
      out_key_ff <= out_key_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_key_ff;
   assign rsp_tlast = out_last_ff;

endmodule
`default_nettype wire

[sv/lcg_keyed_xor_stream_cipher.sv]
// Top level of the LCG keyed XOR stream cipher: front end, command queue and back end.
// An encrypt response is registered; one request per cycle while the response side is ready.
// A new-key request gives 32 key characters, each from a generator step, a reciprocal
// multiply and a remainder and lookup, once the key sequencer takes it from the queue;
// the key sequencer paces the characters and holds while the response side stalls.
// A reseed request loads the generator from the seed and gives no response.
// Synchronous reset clears the seed, generator state, key position and key store at once.
`timescale 1ns / 1ps
`default_nettype none
module lcg_keyed_xor_stream_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [1:0] action, [9:2] data_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // [7:0] data_out
   output logic             rsp_tuser,  // [0] is_key
   output logic             rsp_tlast
);
   import lkx_pkg::*;

   q_status_type q_stat;
   q_entry_type  q_wdata;
   q_entry_type  q_rdata;
   logic         q_push;
   logic         q_pop;

   lkx_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   lkx_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_stat  (q_stat)
   );

   lkx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .q_rdata    (q_rdata),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("Back end popped an empty queue.");

   a_cipher_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("Ciphertext response without last flag.");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("Response valid right after reset.");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("Front end pushed into a full queue.");

endmodule
`default_nettype wire

[dv/lcg_keyed_xor_stream_cipher_tb.sv]
// Self-checking testbench for the LCG keyed XOR stream cipher with a predicting scoreboard.
`timescale 1ns / 1ps
module lcg_keyed_xor_stream_cipher_tb;
   import lkx_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 10;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS = 50;

   typedef struct packed {
      logic [7:0] data;
      logic       is_key;
      logic       last;
   } cipher_beat_type;

   class keystream_tracker;
      logic [31:0]     seed_reg;
      logic [31:0]     lcg_state;
      logic [7:0]      key_chars[KEY_LEN];
      int unsigned     key_pos;
      cipher_beat_type expected_beats[$];
      int unsigned     mismatches;
      string           charset_text;

      function new();
         charset_text = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ123456789";
         seed_reg = '0;
         lcg_state = '0;
         foreach (key_chars[i]) key_chars[i] = '0;
         key_pos = 0;
         mismatches = 0;
      endfunction

      function void write_seed(logic [31:0] value);
         seed_reg = value;
      endfunction

      function void note_request(logic [1:0] act, logic [7:0] din);
         logic [14:0]     draw;
         cipher_beat_type beat;
         case (act)
            ACT_RESEED: begin
               lcg_state = seed_reg;
            end
            ACT_KEYGEN: begin
               for (int k = 0; k < KEY_LEN; k++) begin
                  lcg_state = lcg_state * 32'd214013 + 32'd2531011;
                  draw = lcg_state[30:16];
                  key_chars[k] = charset_text[draw % 61];
                  beat.data = key_chars[k];
                  beat.is_key = 1'b1;
                  beat.last = (k == KEY_LEN - 1);
                  expected_beats.push_back(beat);
               end
               key_pos = 0;
            end
            ACT_ENCRYPT: begin
               beat.data = din ^ key_chars[key_pos];
               beat.is_key = 1'b0;
               beat.last = 1'b1;
               expected_beats.push_back(beat);
               key_pos = (key_pos + 1) % KEY_LEN;
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(logic [7:0] data, logic is_key, logic last);
         cipher_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected response: data_out %02h is_key %0b last %0b", data, is_key, last);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         if (data !== want.data) begin
            $error("data_out mismatch: expected %02h, actual %02h", want.data, data);
            mismatches++;
         end
         if (is_key !== want.is_key) begin
            $error("is_key mismatch: expected %0b, actual %0b", want.is_key, is_key);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wen;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   keystream_tracker board = new();
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned request_count = 0;

   lcg_keyed_xor_stream_cipher dut (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // The receiver alternates between open stretches, hard stalls and coin-flip readiness.
   initial begin
      int unsigned run_left;
      int unsigned stall_left;
      rsp_tready = 1'b0;
      run_left = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_tready = 1'b1;
            run_left--;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  rsp_tready = 1'b1;
                  run_left = $urandom_range(1, 40);
               end
               1: begin
                  rsp_tready = 1'b0;
                  stall_left = $urandom_range(1, 12);
               end
               default: begin
                  rsp_tready = 1'($urandom_range(0, 1));
               end
            endcase
         end
      end
   end

   task automatic send_request(input logic [1:0] act, input logic [7:0] din);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tdata = {6'b0, din, act};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(act, din);
      request_count++;
      @(negedge clock);
   endtask

   task automatic write_seed_when_idle(input logic [31:0] value);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wdata = value;
      csr_wen = 1'b1;
      board.write_seed(value);
      @(negedge clock);
      csr_wen = 1'b0;
      burst_left = 0;
   endtask

   // Most traffic is a reseed and a fresh key followed by a byte stream; the rest is noise.
   task automatic run_phase(input logic [31:0] value, input int unsigned items);
      int unsigned sent;
      int unsigned pick;
      write_seed_when_idle(value);
      send_request(ACT_RESEED, 8'($urandom_range(0, 255)));
      send_request(ACT_KEYGEN, 8'($urandom_range(0, 255)));
      sent = 2;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            send_request(ACT_ENCRYPT, 8'($urandom_range(0, 255)));
            sent++;
         end else if (pick < 88) begin
            send_request(ACT_KEYGEN, 8'($urandom_range(0, 255)));
            sent++;
         end else if (pick < 93) begin
            send_request(ACT_RESEED, 8'($urandom_range(0, 255)));
            sent++;
         end else begin
            send_request(ACT_NONE, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Before any key the cleared store passes bytes through unchanged.
      send_request(ACT_ENCRYPT, 8'h00);
      send_request(ACT_ENCRYPT, 8'hFF);
      send_request(ACT_ENCRYPT, 8'h5A);
      send_request(ACT_NONE, 8'hFF);
      send_request(ACT_KEYGEN, 8'h00);
      send_request(ACT_ENCRYPT, 8'h00);
      send_request(ACT_ENCRYPT, 8'hFF);
      send_request(ACT_RESEED, 8'hFF);
      send_request(ACT_KEYGEN, 8'hFF);
      send_request(ACT_ENCRYPT, 8'hA5);
      write_seed_when_idle(32'hFFFF_FFFF);
      send_request(ACT_RESEED, 8'h00);
      send_request(ACT_KEYGEN, 8'h00);
      send_request(ACT_ENCRYPT, 8'hFF);
      send_request(ACT_ENCRYPT, 8'h00);
      send_request(ACT_NONE, 8'h00);
      send_request(ACT_ENCRYPT, 8'h55);
      send_request(ACT_KEYGEN, 8'hAA);
      send_request(ACT_ENCRYPT, 8'hAA);

      run_phase(32'h0000_0000, PHASE_ITEMS);
      run_phase(32'h8000_0000, PHASE_ITEMS);
      run_phase(32'h7FFF_FFFF, PHASE_ITEMS);
      run_phase($urandom(), PHASE_ITEMS);
      run_phase($urandom(), PHASE_ITEMS);
      run_phase($urandom(), PHASE_ITEMS);

      req_tvalid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (board.pending() != 0) begin
            $error("%0d expected responses never arrived", board.pending());
         end
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
